// ===== rtl/core/huffman_bit_packer_unit_defines.svh =====
// Assertion macros used by the checker file of the bit packer.
// Each macro expects clk and rst_n to be visible in the scope that uses it.
`ifndef HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hbp_pkg.sv =====
package hbp_pkg;

  // Table geometry
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOLS      = 256;
  localparam int SYM_AW       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // Field widths
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;

  // Pending bit buffer: at most seven bits wait between symbols
  localparam int PEND_MAX   = 7;
  localparam int PEND_CNT_W = 3;

  // Stored length and accumulator widths
  localparam int SLEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ACC_W  = PEND_MAX + MAX_CODE_LEN;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } hbp_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } hbp_state_t;

  // Table access from the input side
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } hbp_tbl_req_t;

  // Table answer, registered, in the cycle after the read; len is zero for an absent code
  typedef struct packed {
    logic [SLEN_W-1:0]       len;
    logic [MAX_CODE_LEN-1:0] bits;
  } hbp_lookup_t;

  // Commands into the packer
  typedef struct packed {
    logic encode;
    logic flush;
  } hbp_cmd_t;

endpackage

// ===== rtl/core/hbp_in_if.sv =====
interface hbp_in_if;
  import hbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [CODE_W-1:0] code_bits;

  modport source (output valid, output opcode, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink   (input valid, input opcode, input symbol, input code_length,
                  input code_bits, output ready);
endinterface

// ===== rtl/core/hbp_out_if.sv =====
interface hbp_out_if;
  import hbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/hbp_ram.sv =====
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/hbp_table.sv =====
module hbp_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hbp_pkg::hbp_tbl_req_t req,
  output hbp_pkg::hbp_lookup_t  rsp
);
  import hbp_pkg::*;

  localparam int ENT_W = SLEN_W + MAX_CODE_LEN;

  logic                in_range;
  logic [SYM_AW-1:0]   addr;
  logic [LEN_W-1:0]    len_sat;
  logic [CODE_W-1:0]   code_mask;
  logic [ENT_W-1:0]    wr_data;
  logic [ENT_W-1:0]    rd_data;
  logic                wr_en;
  logic [SYMBOLS-1:0]  vld_r;
  logic [SYMBOLS-1:0]  vld_nxt;
  logic                hit_r;
  logic                hit_nxt;

  // Decode the entry address; symbols past the table never hit
  assign in_range = ({1'b0, req.sym} < (SYM_W + 1)'(SYMBOLS));
  assign addr     = req.sym[SYM_AW-1:0];

  // Saturate the length and drop code bits above it
  assign len_sat   = (req.len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : req.len;
  assign code_mask = ~({CODE_W{1'b1}} << len_sat);
  assign wr_data   = {SLEN_W'(len_sat), MAX_CODE_LEN'(req.bits & code_mask)};
  assign wr_en     = req.wr_en && in_range;

  // Mark written entries; an unmarked entry reads as length zero
  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[addr] = 1'b1;
    end
  end

  assign hit_nxt = req.rd_en && in_range && vld_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  hbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOLS)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Hand the entry to the packer; an absent code carries no bits
  assign rsp.len  = hit_r ? rd_data[ENT_W-1:MAX_CODE_LEN] : '0;
  assign rsp.bits = hit_r ? rd_data[MAX_CODE_LEN-1:0] : '0;

endmodule

// ===== rtl/core/hbp_packer.sv =====
module hbp_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hbp_pkg::hbp_cmd_t          cmd,
  input  hbp_pkg::hbp_lookup_t       rsp,
  output logic                       idle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hbp_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import hbp_pkg::*;

  localparam int FL_W = PEND_MAX + BYTE_W;
  localparam int SH_W = $clog2(BYTE_W + 1);

  hbp_state_t state_r, state_nxt;

  logic [PEND_MAX-1:0]   pend_r, pend_nxt;
  logic [PEND_CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [ACC_W-1:0]      look_acc;
  logic [CNT_W-1:0]      look_cnt;
  logic                  look_emits;
  logic                  out_free;
  logic [CNT_W-1:0]      emit_cnt;
  logic [BYTE_W-1:0]     emit_byte;
  logic                  emit_last;
  logic [PEND_MAX-1:0]   rem_mask;
  logic [BYTE_W-1:0]     flush_byte;

  // Append the looked-up code behind the pending bits
  assign look_acc   = (ACC_W'(pend_r) << rsp.len) | ACC_W'(rsp.bits);
  assign look_cnt   = CNT_W'(pcnt_r) + CNT_W'(rsp.len);
  assign look_emits = (look_cnt >= CNT_W'(BYTE_W));

  // Take the oldest whole byte off the accumulator
  assign out_free  = !out_valid_r || out_ready;
  assign emit_cnt  = cnt_r - CNT_W'(BYTE_W);
  assign emit_byte = BYTE_W'(acc_r >> emit_cnt);
  assign emit_last = (emit_cnt < CNT_W'(BYTE_W));
  assign rem_mask  = ~({PEND_MAX{1'b1}} << emit_cnt[PEND_CNT_W-1:0]);

  // Left-align the pending bits into one zero-padded byte
  assign flush_byte = BYTE_W'(FL_W'(pend_r) << (SH_W'(BYTE_W) - SH_W'(pcnt_r)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        priority if (cmd.encode) begin
          state_nxt = ST_LOOKUP;
        end else if (cmd.flush) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        state_nxt = look_emits ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output register
  always_comb begin
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.flush && !cmd.encode) begin
          acc_nxt  = ACC_W'(flush_byte);
          cnt_nxt  = CNT_W'(BYTE_W);
          pend_nxt = '0;
          pcnt_nxt = '0;
        end
      end
      ST_LOOKUP: begin
        acc_nxt = look_acc;
        cnt_nxt = look_cnt;
        if (!look_emits) begin
          pend_nxt = look_acc[PEND_MAX-1:0];
          pcnt_nxt = look_cnt[PEND_CNT_W-1:0];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cnt_nxt       = emit_cnt;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            pend_nxt = acc_r[PEND_MAX-1:0] & rem_mask;
            pcnt_nxt = emit_cnt[PEND_CNT_W-1:0];
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/huffman_bit_packer_unit.sv =====
// Huffman bit packer with a loadable 256-entry code table.
// in_port carries one command word: opcode, symbol, code_length, code_bits.
//   Load writes a symbol's code (length capped at 32) into the table.
//   Encode looks the symbol up and appends its code, first bit first.
//   Flush sends one byte holding the pending bits, left-aligned, zero padded.
// out_port carries packed words, earliest bit in bit 7, with last set on the
// final word a command produces. An encode produces zero to four words.
// Load and an unused opcode leave the packer idle. Flush moves to the emit
// state; encode first reads the table (a registered read), then sends one
// word per cycle, unless the receiver stalls, from a single output register.
// A command whose words are all handed to the output register frees the
// input, so the next command is taken while the final word still waits.
// Reset (rst_n low, synchronous) empties the bit buffer, drops any held word
// and marks every table entry as having no code.
// A stalled receiver holds the output word steady and pauses packing; the
// input stays closed until the current command's words are all queued.
module huffman_bit_packer_unit (
  input logic     clk,
  input logic     rst_n,
  hbp_in_if.sink  in_port,
  hbp_out_if.source out_port
);
  import hbp_pkg::*;

  logic         in_fire;
  logic         pk_idle;
  hbp_tbl_req_t tbl_req;
  hbp_lookup_t  tbl_rsp;
  hbp_cmd_t     pk_cmd;

  // Accept a command only while the packer has nothing in flight
  assign in_port.ready = pk_idle;
  assign in_fire       = in_port.valid && pk_idle;

  // Decode the command into a table access and a packer command
  assign tbl_req.wr_en = in_fire && (in_port.opcode == OP_LOAD);
  assign tbl_req.rd_en = in_fire && (in_port.opcode == OP_ENCODE);
  assign tbl_req.sym   = in_port.symbol;
  assign tbl_req.len   = in_port.code_length;
  assign tbl_req.bits  = in_port.code_bits;

  assign pk_cmd.encode = in_fire && (in_port.opcode == OP_ENCODE);
  assign pk_cmd.flush  = in_fire && (in_port.opcode == OP_FLUSH);

  hbp_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  hbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pk_cmd),
    .rsp       (tbl_rsp),
    .idle      (pk_idle),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .out_byte  (out_port.out_byte),
    .out_last  (out_port.last)
  );

endmodule

// ===== rtl/core/hbp_checker.sv =====
`include "huffman_bit_packer_unit_defines.svh"

module hbp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [hbp_pkg::OP_W-1:0]   in_opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hbp_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last
);
  import hbp_pkg::*;

  logic in_fire;
  logic out_fire;
  logic busy_op;
  logic quick_op;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign busy_op  = (in_opcode == OP_ENCODE) || (in_opcode == OP_FLUSH);
  assign quick_op = (in_opcode != OP_ENCODE) && (in_opcode != OP_FLUSH);

  // A stalled word holds its value
  `HBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "output word changed while stalled")

  // Encode and flush close the input in the cycle after they are taken
  `HBP_ASSERT_NEXT(a_busy_after_cmd, in_fire && busy_op, !in_ready, "input open right after encode or flush")

  // Load and unused opcodes leave the input open
  `HBP_ASSERT_NEXT(a_load_quick, in_fire && quick_op, in_ready, "input closed after a load")

  // A word that is not the last one keeps the input closed
  `HBP_ASSERT_NOW(a_mid_cmd_closed, out_valid && !out_last, !in_ready, "input open in the middle of a command")

  // Taking a non-final word brings the next word at once
  `HBP_ASSERT_NEXT(a_next_word, out_fire && !out_last, out_valid, "gap after a non-final word")

endmodule

bind huffman_bit_packer_unit hbp_checker u_hbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_port.valid),
  .in_ready  (in_port.ready),
  .in_opcode (in_port.opcode),
  .out_valid (out_port.valid),
  .out_ready (out_port.ready),
  .out_byte  (out_port.out_byte),
  .out_last  (out_port.last)
);

// ===== tb/tb.sv =====
module tb;
  import hbp_pkg::*;

  localparam bit [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOT_COUNT = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // Tracks the code table and the bit buffer, and queues the bytes each command makes
  class code_stream_scoreboard;
    bit [LEN_W-1:0]  code_len [SYMBOLS];
    bit [CODE_W-1:0] code_val [SYMBOLS];
    bit [6:0]        pend_bits;
    bit [2:0]        pend_cnt;
    packed_byte_t    expected_bytes[$];
    int              mismatch_count;

    function new();
      foreach (code_len[i]) begin
        code_len[i] = '0;
        code_val[i] = '0;
      end
      pend_bits = '0;
      pend_cnt = '0;
      mismatch_count = 0;
    endfunction

    function void take_command(bit [OP_W-1:0] op, bit [SYM_W-1:0] sym,
                               bit [LEN_W-1:0] len, bit [CODE_W-1:0] bits);
      int unsigned clen;
      int unsigned cnt;
      int          n;
      bit [63:0]   acc;
      bit [15:0]   pad;
      packed_byte_t w;
      case (op)
        OP_LOAD: begin
          // cap the length, drop bits above it
          clen = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
          code_len[sym] = LEN_W'(clen);
          code_val[sym] = CODE_W'(bits & ((64'd1 << clen) - 64'd1));
        end
        OP_ENCODE: begin
          clen = code_len[sym];
          if (clen != 0) begin
            acc = (64'(pend_bits) << clen) | 64'(code_val[sym]);
            cnt = pend_cnt + clen;
            n = 0;
            // emit whole bytes, earliest bit first
            while (cnt >= BYTE_W && n < 4) begin
              cnt -= BYTE_W;
              w.data = 8'((acc >> cnt) & 64'hFF);
              w.last = 1'b0;
              expected_bytes.push_back(w);
              n++;
            end
            if (n > 0) expected_bytes[$].last = 1'b1;
            pend_bits = 7'(acc & ((64'd1 << cnt) - 64'd1));
            pend_cnt = 3'(cnt);
          end
        end
        OP_FLUSH: begin
          // left-align the leftover bits, pad with zeros
          pad = 16'(pend_bits) << (BYTE_W - pend_cnt);
          w.data = pad[7:0];
          w.last = 1'b1;
          expected_bytes.push_back(w);
          pend_bits = '0;
          pend_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(bit [BYTE_W-1:0] data, bit last);
      packed_byte_t w;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, data, last);
        mismatch_count++;
      end else begin
        w = expected_bytes.pop_front();
        if (w.data !== data) begin
          $display("%0t: byte mismatch: expected %02h, actual %02h", $time, w.data, data);
          mismatch_count++;
        end
        if (w.last !== last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, w.last, last);
          mismatch_count++;
        end
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   in_steady;
  bit   out_steady;
  bit [SYM_W-1:0] hot_syms [HOT_COUNT];
  code_stream_scoreboard sb;

  hbp_in_if  in_if();
  hbp_out_if out_if();

  huffman_bit_packer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one command word after a random gap and hold it until taken
  task automatic send_command(bit [OP_W-1:0] op, bit [SYM_W-1:0] sym,
                              bit [LEN_W-1:0] len, bit [CODE_W-1:0] bits);
    int gap;
    if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.symbol      <= sym;
    in_if.code_length <= len;
    in_if.code_bits   <= bits;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    sb.take_command(op, sym, len, bits);
  endtask

  // Accept output words with random stalls and check each one
  task automatic drain_bytes();
    int stall;
    forever begin
      if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      sb.check_byte(out_if.out_byte, out_if.last);
    end
  endtask

  // Mostly short codes, some long ones, a few beyond the cap
  function automatic bit [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 90) return LEN_W'($urandom_range(13, MAX_CODE_LEN));
    return LEN_W'($urandom_range(0, 63));
  endfunction

  task automatic run_directed();
    send_command(OP_FLUSH, 8'd0, 6'd0, 32'd0);             // flush with nothing pending
    send_command(OP_LOAD, 8'd0, 6'd0, 32'hFFFF_FFFF);      // zero-length code
    send_command(OP_ENCODE, 8'd0, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd200, 6'd0, 32'd0);          // never loaded
    send_command(OP_LOAD, 8'd1, 6'd1, 32'hFFFF_FFFF);      // excess bits dropped
    send_command(OP_LOAD, 8'd255, 6'd32, 32'hA5C3_0FF1);
    send_command(OP_LOAD, 8'd2, 6'd63, 32'h8000_0001);     // overlong, capped
    send_command(OP_LOAD, 8'd3, 6'd33, 32'h1234_5678);
    send_command(OP_LOAD, 8'd4, 6'd8, 32'hFFFF_FF5A);
    send_command(OP_UNUSED, 8'd1, 6'd5, 32'hFFFF_FFFF);    // ignored opcode
    send_command(OP_ENCODE, 8'd1, 6'd0, 32'd0);
    send_command(OP_FLUSH, 8'd0, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd4, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd1, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd255, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd2, 6'd0, 32'd0);
    send_command(OP_ENCODE, 8'd3, 6'd0, 32'd0);
    send_command(OP_FLUSH, 8'd0, 6'd0, 32'd0);
    send_command(OP_LOAD, 8'd1, 6'd7, 32'h0000_0055);
    send_command(OP_ENCODE, 8'd1, 6'd0, 32'd0);            // seven bits pending
    send_command(OP_ENCODE, 8'd255, 6'd0, 32'd0);          // widest accumulation
    send_command(OP_FLUSH, 8'd0, 6'd0, 32'd0);
    send_command(OP_LOAD, 8'd4, 6'd0, 32'd0);              // clear an entry
    send_command(OP_ENCODE, 8'd4, 6'd0, 32'd0);
    send_command(OP_FLUSH, 8'd0, 6'd0, 32'd0);
  endtask

  task automatic run_random();
    int r;
    bit [SYM_W-1:0] sym;
    // load a working set of symbols first
    foreach (hot_syms[i]) begin
      hot_syms[i] = SYM_W'($urandom_range(0, 255));
      send_command(OP_LOAD, hot_syms[i], pick_length(), $urandom());
    end
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_command(OP_ENCODE, hot_syms[$urandom_range(0, HOT_COUNT - 1)],
                     LEN_W'($urandom_range(0, 63)), $urandom());
      end else if (r < 65) begin
        send_command(OP_ENCODE, SYM_W'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 63)), $urandom());
      end else if (r < 80) begin
        sym = ($urandom_range(0, 9) < 6) ? hot_syms[$urandom_range(0, HOT_COUNT - 1)]
                                         : 8'($urandom_range(0, 255));
        send_command(OP_LOAD, sym, pick_length(), $urandom());
      end else if (r < 97) begin
        send_command(OP_FLUSH, SYM_W'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 63)), $urandom());
      end else begin
        send_command(OP_UNUSED, SYM_W'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 63)), $urandom());
      end
    end
  endtask

  initial begin
    sb = new();
    in_steady = 1'b0;
    out_steady = 1'b0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= '0;
    in_if.symbol      <= '0;
    in_if.code_length <= '0;
    in_if.code_bits   <= '0;
    out_if.ready      <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_bytes();
    join_none
    run_directed();
    run_random();
    in_if.valid <= 1'b0;
    // wait for every expected byte, then let the pipeline settle
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
